### hdl/axis_angle_vector_rotate_defines.svh
// Assertion macros used by the vector rotation control block.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH
`ifndef SYNTH
// Check a property on clk, skipped while rst is high.
`define AAVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on clk, reset cycles included.
`define AAVR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AAVR_ASSERT(lbl, prop, msg)
`define AAVR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hdl/aavr_pkg.sv
// Package: types, stage map and series constants of the vector rotation pipeline.
`timescale 1ns / 1ps
package aavr_pkg;

  localparam int ANGLE_BITS = 16;

  // Stage map (register stage numbers, 1 based)
  localparam int ST_IN    = 1;
  localparam int ST_X     = 2;
  localparam int ST_X2    = 3;
  localparam int ST_TERM0 = 4;
  localparam int ST_SFIN  = 16;
  localparam int ST_SC    = 18;
  localparam int ST_M1    = 19;
  localparam int ST_M2    = 20;
  localparam int ST_M3    = 21;
  localparam int ST_D1    = 22;
  localparam int ST_D2    = 23;
  localparam int ST_D3    = 24;
  localparam int ST_D4    = 25;
  localparam int N_STAGES = ST_D4;

  typedef logic [N_STAGES:1] stage_en_t;
  typedef logic [30:0] q30_t;
  typedef logic signed [35:0] entry_t;
  typedef logic signed [31:0] comp_t;

  typedef enum logic [1:0] {
    OP_AXIS  = 2'd0,
    OP_ROT_X = 2'd1,
    OP_ROT_Y = 2'd2,
    OP_ROT_Z = 2'd3
  } op_t;

  localparam q30_t ONE_Q30 = 31'h4000_0000;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  localparam int N_SIN_TERMS = 4;
  localparam int N_COS_TERMS = 5;
  localparam logic [6:0] SIN_DIV [N_SIN_TERMS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [N_COS_TERMS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam q30_t SIN_RECIP [N_SIN_TERMS] = '{
    31'(64'd2147483648 / 64'd72), 31'(64'd2147483648 / 64'd42),
    31'(64'd2147483648 / 64'd20), 31'(64'd2147483648 / 64'd6)};
  localparam q30_t COS_RECIP [N_COS_TERMS] = '{
    31'(64'd2147483648 / 64'd90), 31'(64'd2147483648 / 64'd56),
    31'(64'd2147483648 / 64'd30), 31'(64'd2147483648 / 64'd12),
    31'(64'd2147483648 / 64'd2)};

endpackage

### hdl/axis_angle_vector_rotate.sv
// Top level: pipelined axis-angle and single-axis rotation of Q16.16 vectors.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | opcode, vec_x..z, axis_x..z, angle
//   out     | output    | out_valid / out_ready| rot_x..z, saturated
//
// One request per cycle sustained while out is not stalled; the sine and cosine
// series: five dependent multiply, reciprocal and correct steps of three stages each.
// rst is synchronous and clears only the valid bits; no clearing pass.
// A stall on out holds the last stage; empty stages upstream keep filling, so
// in_ready stays high while any stage is empty.
`timescale 1ns / 1ps
module axis_angle_vector_rotate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic signed [31:0]              vec_x,
  input  logic signed [31:0]              vec_y,
  input  logic signed [31:0]              vec_z,
  input  logic signed [15:0]              axis_x,
  input  logic signed [15:0]              axis_y,
  input  logic signed [15:0]              axis_z,
  input  logic [aavr_pkg::ANGLE_BITS-1:0] angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              rot_x,
  output logic signed [31:0]              rot_y,
  output logic signed [31:0]              rot_z,
  output logic                            saturated
);
  import aavr_pkg::*;

  stage_en_t          en;
  comp_t              sin_q, cos_q;
  entry_t             ent [0:2][0:2];
  logic [1:0]         op_d [ST_IN:ST_SC];
  logic signed [15:0] ax_d [ST_IN:ST_SC];
  logic signed [15:0] ay_d [ST_IN:ST_SC];
  logic signed [15:0] az_d [ST_IN:ST_SC];
  comp_t              vx_d [ST_IN:ST_M3];
  comp_t              vy_d [ST_IN:ST_M3];
  comp_t              vz_d [ST_IN:ST_M3];

  aavr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .en        (en)
  );

  // Carry the request payload alongside the sine and cosine stages
  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      op_d[ST_IN] <= opcode;
      ax_d[ST_IN] <= axis_x;
      ay_d[ST_IN] <= axis_y;
      az_d[ST_IN] <= axis_z;
      vx_d[ST_IN] <= vec_x;
      vy_d[ST_IN] <= vec_y;
      vz_d[ST_IN] <= vec_z;
    end
    for (int k = ST_IN + 1; k <= ST_SC; k++) begin
      if (en[k]) begin
        op_d[k] <= op_d[k-1];
        ax_d[k] <= ax_d[k-1];
        ay_d[k] <= ay_d[k-1];
        az_d[k] <= az_d[k-1];
      end
    end
    for (int k = ST_IN + 1; k <= ST_M3; k++) begin
      if (en[k]) begin
        vx_d[k] <= vx_d[k-1];
        vy_d[k] <= vy_d[k-1];
        vz_d[k] <= vz_d[k-1];
      end
    end
  end

  aavr_sincos u_sincos (
    .clk   (clk),
    .en    (en),
    .angle (angle),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  aavr_matrix u_matrix (
    .clk    (clk),
    .en     (en),
    .opcode (op_d[ST_SC]),
    .axis_x (ax_d[ST_SC]),
    .axis_y (ay_d[ST_SC]),
    .axis_z (az_d[ST_SC]),
    .sin_q  (sin_q),
    .cos_q  (cos_q),
    .ent    (ent)
  );

  aavr_dot u_dot (
    .clk       (clk),
    .en        (en),
    .ent       (ent),
    .vec_x     (vx_d[ST_M3]),
    .vec_y     (vy_d[ST_M3]),
    .vec_z     (vz_d[ST_M3]),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .saturated (saturated)
  );

endmodule

### hdl/aavr_term.sv
// One series step: t_out = ONE - round_mul(x2, t_in) / div, over three stages.
`timescale 1ns / 1ps
module aavr_term (
  input  logic          clk,
  input  logic [2:0]    en,
  input  logic [6:0]    div,
  input  aavr_pkg::q30_t recip,
  input  aavr_pkg::q30_t x2_in,
  input  aavr_pkg::q30_t t_in,
  output aavr_pkg::q30_t x2_out,
  output aavr_pkg::q30_t t_out
);
  import aavr_pkg::*;

  logic [61:0] prod_m;
  logic [61:0] prod_r;
  q30_t        p_m, x2_m;
  q30_t        q0_r, p_r, x2_r;
  logic [37:0] qd;
  q30_t        rem;
  q30_t        q;

  // Q30 product with rounding
  assign prod_m = 62'(x2_in) * 62'(t_in) + 62'h2000_0000;
  // Reciprocal estimate of p / div, low by at most one
  assign prod_r = 62'(p_m) * 62'(recip);
  // Correct the estimate
  assign qd  = 38'(q0_r) * 38'(div);
  assign rem = 31'(38'(p_r) - qd);
  assign q   = (rem >= 31'(div)) ? q0_r + 31'd1 : q0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_m  <= prod_m[60:30];
      x2_m <= x2_in;
    end
    if (en[1]) begin
      q0_r <= prod_r[61:31];
      p_r  <= p_m;
      x2_r <= x2_m;
    end
    if (en[2]) begin
      t_out  <= ONE_Q30 - q;
      x2_out <= x2_r;
    end
  end

endmodule

### hdl/aavr_sincos.sv
// Sine and cosine of a turn fraction: octant fold, radians, and parallel series lanes.
`timescale 1ns / 1ps
module aavr_sincos (
  input  logic                              clk,
  input  aavr_pkg::stage_en_t               en,
  input  logic [aavr_pkg::ANGLE_BITS-1:0]   angle,
  output aavr_pkg::comp_t                   sin_q,
  output aavr_pkg::comp_t                   cos_q
);
  import aavr_pkg::*;

  logic [31:0] turn;
  logic [29:0] r1;
  logic [63:0] xprod;
  logic [61:0] xxprod;
  logic [61:0] sprod;
  logic [2:0]  oct_d [ST_IN:ST_SC];
  q30_t        x_d [ST_X:ST_SFIN-1];
  q30_t        x2;
  q30_t        s0_d [ST_SFIN:ST_SC];
  q30_t        t_s [0:N_SIN_TERMS];
  q30_t        x2_s [0:N_SIN_TERMS];
  q30_t        t_c [0:N_COS_TERMS];
  q30_t        x2_c [0:N_COS_TERMS];
  comp_t       s0e, c0e;

  // Fold the angle into the first octant
  assign turn  = {angle, {(32 - ANGLE_BITS){1'b0}}};
  assign xprod = 64'(r1) * 64'(TWO_PI_Q30) + 64'h8000_0000;
  assign xxprod = 62'(x_d[ST_X]) * 62'(x_d[ST_X]) + 62'h2000_0000;
  assign sprod = 62'(x_d[ST_SFIN-1]) * 62'(t_s[N_SIN_TERMS]) + 62'h2000_0000;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      r1 <= turn[29] ? 30'h2000_0000 - 30'(turn[28:0]) : 30'(turn[28:0]);
      oct_d[ST_IN] <= turn[31:29];
    end
    for (int k = ST_IN + 1; k <= ST_SC; k++) begin
      if (en[k]) oct_d[k] <= oct_d[k-1];
    end
    if (en[ST_X]) x_d[ST_X] <= xprod[62:32];
    if (en[ST_X2]) x2 <= xxprod[60:30];
    for (int k = ST_X + 1; k <= ST_SFIN - 1; k++) begin
      if (en[k]) x_d[k] <= x_d[k-1];
    end
    if (en[ST_SFIN]) s0_d[ST_SFIN] <= sprod[60:30];
    for (int k = ST_SFIN + 1; k <= ST_SC; k++) begin
      if (en[k]) s0_d[k] <= s0_d[k-1];
    end
  end

  // Series lanes, both seeded with one
  assign t_s[0]  = ONE_Q30;
  assign x2_s[0] = x2;
  assign t_c[0]  = ONE_Q30;
  assign x2_c[0] = x2;

  for (genvar j = 0; j < N_SIN_TERMS; j++) begin : g_sin
    aavr_term u_term (
      .clk    (clk),
      .en     (en[ST_TERM0 + 3 * j +: 3]),
      .div    (SIN_DIV[j]),
      .recip  (SIN_RECIP[j]),
      .x2_in  (x2_s[j]),
      .t_in   (t_s[j]),
      .x2_out (x2_s[j+1]),
      .t_out  (t_s[j+1])
    );
  end

  for (genvar j = 0; j < N_COS_TERMS; j++) begin : g_cos
    aavr_term u_term (
      .clk    (clk),
      .en     (en[ST_TERM0 + 3 * j +: 3]),
      .div    (COS_DIV[j]),
      .recip  (COS_RECIP[j]),
      .x2_in  (x2_c[j]),
      .t_in   (t_c[j]),
      .x2_out (x2_c[j+1]),
      .t_out  (t_c[j+1])
    );
  end

  // Map the octant back onto sine and cosine
  assign s0e = comp_t'({1'b0, s0_d[ST_SC]});
  assign c0e = comp_t'({1'b0, t_c[N_COS_TERMS]});

  always_comb begin
    case (oct_d[ST_SC])
      3'd0: begin sin_q = s0e;  cos_q = c0e;  end
      3'd1: begin sin_q = c0e;  cos_q = s0e;  end
      3'd2: begin sin_q = c0e;  cos_q = -s0e; end
      3'd3: begin sin_q = s0e;  cos_q = -c0e; end
      3'd4: begin sin_q = -s0e; cos_q = -c0e; end
      3'd5: begin sin_q = -c0e; cos_q = -s0e; end
      3'd6: begin sin_q = -c0e; cos_q = s0e;  end
      default: begin sin_q = -s0e; cos_q = c0e; end
    endcase
  end

endmodule

### hdl/aavr_matrix.sv
// Rotation matrix builder: axis-angle or single-axis entries in Q30.
`timescale 1ns / 1ps
module aavr_matrix (
  input  logic                clk,
  input  aavr_pkg::stage_en_t en,
  input  logic [1:0]          opcode,
  input  logic signed [15:0]  axis_x,
  input  logic signed [15:0]  axis_y,
  input  logic signed [15:0]  axis_z,
  input  aavr_pkg::comp_t     sin_q,
  input  aavr_pkg::comp_t     cos_q,
  output aavr_pkg::entry_t    ent [0:2][0:2]
);
  import aavr_pkg::*;

  localparam entry_t ONE_E = 36'sd1073741824;

  logic signed [15:0] n [0:2];
  logic signed [31:0] nn [0:2][0:2];
  logic signed [47:0] ns1 [0:2];
  logic signed [47:0] ns2 [0:2];
  logic signed [63:0] pr [0:2][0:2];
  logic signed [63:0] e [0:2][0:2];
  logic signed [63:0] er [0:2][0:2];
  logic signed [32:0] omc;
  comp_t              c1, s1, c2, s2;
  logic [1:0]         op1, op2;
  entry_t             ce, se;

  assign n[0] = axis_x;
  assign n[1] = axis_y;
  assign n[2] = axis_z;
  assign ce = 36'(c2);
  assign se = 36'(s2);

  always_ff @(posedge clk) begin
    // Axis products and one minus cosine
    if (en[ST_M1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          nn[i][j] <= 32'(n[i]) * 32'(n[j]);
        end
        ns1[i] <= 48'(n[i]) * 48'(sin_q);
      end
      omc <= 33'sd1073741824 - 33'(cos_q);
      c1  <= cos_q;
      s1  <= sin_q;
      op1 <= opcode;
    end
    // Scale by one minus cosine
    if (en[ST_M2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr[i][j] <= 64'(nn[i][j]) * 64'(omc);
        end
        ns2[i] <= ns1[i];
      end
      c2  <= c1;
      s2  <= s1;
      op2 <= op1;
    end
    if (en[ST_M3]) begin
      case (op2)
        OP_AXIS: begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              ent[i][j] <= 36'(er[i][j]);
            end
          end
        end
        OP_ROT_X: begin
          ent[0][0] <= ONE_E; ent[0][1] <= '0;  ent[0][2] <= '0;
          ent[1][0] <= '0;    ent[1][1] <= ce;  ent[1][2] <= -se;
          ent[2][0] <= '0;    ent[2][1] <= se;  ent[2][2] <= ce;
        end
        OP_ROT_Y: begin
          ent[0][0] <= ce;    ent[0][1] <= '0;    ent[0][2] <= -se;
          ent[1][0] <= '0;    ent[1][1] <= ONE_E; ent[1][2] <= '0;
          ent[2][0] <= se;    ent[2][1] <= '0;    ent[2][2] <= ce;
        end
        default: begin
          ent[0][0] <= ce;    ent[0][1] <= -se;   ent[0][2] <= '0;
          ent[1][0] <= se;    ent[1][1] <= ce;    ent[1][2] <= '0;
          ent[2][0] <= '0;    ent[2][1] <= '0;    ent[2][2] <= ONE_E;
        end
      endcase
    end
  end

  // Sum the Q58 terms and round to Q30
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i == j) begin
          e[i][j] = pr[i][j] + (64'(c2) <<< 28);
        end else if (j == (i + 2) % 3) begin
          e[i][j] = pr[i][j] + (64'(ns2[3 - i - j]) <<< 14);
        end else begin
          e[i][j] = pr[i][j] - (64'(ns2[3 - i - j]) <<< 14);
        end
        er[i][j] = (e[i][j] + 64'sd134217728) >>> 28;
      end
    end
  end

endmodule

### hdl/aavr_dot.sv
// Matrix by vector product with exact rounding and 32-bit saturation.
`timescale 1ns / 1ps
module aavr_dot (
  input  logic                clk,
  input  aavr_pkg::stage_en_t en,
  input  aavr_pkg::entry_t    ent [0:2][0:2],
  input  aavr_pkg::comp_t     vec_x,
  input  aavr_pkg::comp_t     vec_y,
  input  aavr_pkg::comp_t     vec_z,
  output aavr_pkg::comp_t     rot_x,
  output aavr_pkg::comp_t     rot_y,
  output aavr_pkg::comp_t     rot_z,
  output logic                saturated
);
  import aavr_pkg::*;

  comp_t              v [0:2];
  logic signed [51:0] ph [0:2][0:2];
  logic signed [48:0] pl [0:2][0:2];
  logic signed [53:0] hi [0:2];
  logic signed [50:0] lo [0:2];
  logic signed [71:0] tot [0:2];
  logic signed [41:0] r3 [0:2];
  comp_t              cl [0:2];
  logic [2:0]         clip;

  assign v[0] = vec_x;
  assign v[1] = vec_y;
  assign v[2] = vec_z;

  // Combine partial sums, round, and clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (72'(hi[i]) <<< 16) + 72'(lo[i]) + 72'sd536870912;
      if (r3[i] > 42'sd2147483647) begin
        cl[i]   = 32'sh7FFF_FFFF;
        clip[i] = 1'b1;
      end else if (r3[i] < -42'sd2147483648) begin
        cl[i]   = 32'sh8000_0000;
        clip[i] = 1'b1;
      end else begin
        cl[i]   = 32'(r3[i]);
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // Split each entry into high and low parts and multiply
    if (en[ST_D1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph[i][j] <= 52'(ent[i][j] >>> 16) * 52'(v[j]);
          pl[i][j] <= 49'($signed({1'b0, ent[i][j][15:0]})) * 49'(v[j]);
        end
      end
    end
    if (en[ST_D2]) begin
      for (int i = 0; i < 3; i++) begin
        hi[i] <= 54'(ph[i][0]) + 54'(ph[i][1]) + 54'(ph[i][2]);
        lo[i] <= 51'(pl[i][0]) + 51'(pl[i][1]) + 51'(pl[i][2]);
      end
    end
    if (en[ST_D3]) begin
      for (int i = 0; i < 3; i++) begin
        r3[i] <= 42'(tot[i] >>> 30);
      end
    end
    if (en[ST_D4]) begin
      rot_x     <= cl[0];
      rot_y     <= cl[1];
      rot_z     <= cl[2];
      saturated <= |clip;
    end
  end

endmodule

### hdl/aavr_ctrl.sv
// Pipeline control: per-stage valid bits and load enables with bubble collapse.
`timescale 1ns / 1ps
`include "axis_angle_vector_rotate_defines.svh"
module aavr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output aavr_pkg::stage_en_t en
);
  import aavr_pkg::*;

  stage_en_t valid;
  stage_en_t full;

  // A stage loads when some stage at or after it is empty, or the output drains
  always_comb begin
    for (int k = 1; k <= N_STAGES; k++) begin
      full  = valid | ~(stage_en_t'('1) << (k - 1));
      en[k] = out_ready || !(&full);
    end
  end

  assign in_ready  = en[1];
  assign out_valid = valid[N_STAGES];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[1]) valid[1] <= in_valid;
      for (int k = 2; k <= N_STAGES; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
    end
  end

  `AAVR_ASSERT(a_bubble_ready, !(&valid) |-> in_ready, "request refused with a bubble in the pipe")
  `AAVR_ASSERT(a_count, !$past(rst) |-> ($countones(valid) == $countones($past(valid)) + 32'($past(in_valid && in_ready)) - 32'($past(out_valid && out_ready))), "request count lost or duplicated")
  `AAVR_ASSERT_RST(a_rst_clear, rst |=> (valid == '0), "valid bits not cleared by reset")

endmodule

### test/tb_axis_angle_vector_rotate.sv
// Testbench for the axis-angle vector rotation pipeline: directed and random requests.
`timescale 1ns / 1ps
module tb_axis_angle_vector_rotate;
  import aavr_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } rot_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] opcode;
  logic signed [31:0] vec_x, vec_y, vec_z;
  logic signed [15:0] axis_x, axis_y, axis_z;
  logic [ANGLE_BITS-1:0] angle;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] rot_x, rot_y, rot_z;
  logic saturated;

  int mismatches = 0;
  int rx_cycle = 0;
  bit stim_done = 0;

  axis_angle_vector_rotate i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .saturated(saturated)
  );

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  class rotate_scoreboard;
    rot_t pending[$];

    // Q30 multiply with round half up
    function longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Sine and cosine in Q30 from a turn fraction, by octant and truncated series
    function void sin_cos(input logic [ANGLE_BITS-1:0] ang, output wide_t sn, output wide_t cs);
      logic [31:0] turn;
      logic [2:0] oct;
      longint unsigned r, x, x2, t;
      wide_t s0, c0;
      turn = 32'(ang) << (32 - ANGLE_BITS);
      oct = turn[31:29];
      r = turn[28:0];
      if (oct[0]) r = (64'd1 << 29) - r;
      x = (r * 64'd6746518852 + (64'd1 << 31)) >> 32;
      x2 = mul_q30(x, x);
      t = (64'd1 << 30) - x2 / 72;
      t = (64'd1 << 30) - mul_q30(x2, t) / 42;
      t = (64'd1 << 30) - mul_q30(x2, t) / 20;
      t = (64'd1 << 30) - mul_q30(x2, t) / 6;
      s0 = wide_t'(mul_q30(x, t));
      t = (64'd1 << 30) - x2 / 90;
      t = (64'd1 << 30) - mul_q30(x2, t) / 56;
      t = (64'd1 << 30) - mul_q30(x2, t) / 30;
      t = (64'd1 << 30) - mul_q30(x2, t) / 12;
      t = (64'd1 << 30) - mul_q30(x2, t) / 2;
      c0 = wide_t'(t);
      case (oct)
        3'd0: begin sn = s0;  cs = c0;  end
        3'd1: begin sn = c0;  cs = s0;  end
        3'd2: begin sn = c0;  cs = -s0; end
        3'd3: begin sn = s0;  cs = -c0; end
        3'd4: begin sn = -s0; cs = -c0; end
        3'd5: begin sn = -c0; cs = -s0; end
        3'd6: begin sn = -c0; cs = s0;  end
        default: begin sn = -s0; cs = c0; end
      endcase
    endfunction

    // Build the rotation matrix, apply it and clamp each component
    function rot_t rotate(logic [1:0] op, logic signed [31:0] vx, logic signed [31:0] vy,
                          logic signed [31:0] vz, logic signed [15:0] nx,
                          logic signed [15:0] ny, logic signed [15:0] nz,
                          logic [ANGLE_BITS-1:0] ang);
      wide_t m[3][3];
      wide_t v[3], n[3];
      wide_t s, c, one, omc, acc;
      wide_t lim_hi, lim_lo;
      logic signed [31:0] res[3];
      rot_t o;
      one = wide_t'(1) <<< 30;
      lim_hi = wide_t'(32'sh7fffffff);
      lim_lo = -lim_hi - 1;
      v[0] = vx; v[1] = vy; v[2] = vz;
      n[0] = nx; n[1] = ny; n[2] = nz;
      sin_cos(ang, s, c);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = 0;
      o.sat = 1'b0;
      case (op_t'(op))
        OP_AXIS: begin
          omc = one - c;
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
              m[i][j] = n[i] * n[j] * omc;
              if (i == j) m[i][j] += c * (wide_t'(1) <<< 28);
            end
          m[0][1] -= n[2] * s * 16384;
          m[1][0] += n[2] * s * 16384;
          m[0][2] += n[1] * s * 16384;
          m[2][0] -= n[1] * s * 16384;
          m[1][2] -= n[0] * s * 16384;
          m[2][1] += n[0] * s * 16384;
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              m[i][j] = (m[i][j] + (wide_t'(1) <<< 27)) >>> 28;
        end
        OP_ROT_X: begin
          m[0][0] = one;
          m[1][1] = c; m[1][2] = -s;
          m[2][1] = s; m[2][2] = c;
        end
        OP_ROT_Y: begin
          m[0][0] = c; m[0][2] = -s;
          m[1][1] = one;
          m[2][0] = s; m[2][2] = c;
        end
        default: begin
          m[0][0] = c; m[0][1] = -s;
          m[1][0] = s; m[1][1] = c;
          m[2][2] = one;
        end
      endcase
      for (int i = 0; i < 3; i++) begin
        acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
        acc = (acc + (wide_t'(1) <<< 29)) >>> 30;
        if (acc > lim_hi) begin acc = lim_hi; o.sat = 1'b1; end
        if (acc < lim_lo) begin acc = lim_lo; o.sat = 1'b1; end
        res[i] = acc[31:0];
      end
      o.x = res[0]; o.y = res[1]; o.z = res[2];
      return o;
    endfunction

    function void note_request(logic [1:0] op, logic signed [31:0] vx, logic signed [31:0] vy,
                               logic signed [31:0] vz, logic signed [15:0] nx,
                               logic signed [15:0] ny, logic signed [15:0] nz,
                               logic [ANGLE_BITS-1:0] ang);
      pending.push_back(rotate(op, vx, vy, vz, nx, ny, nz, ang));
    endfunction

    task check_result(logic signed [31:0] rx, logic signed [31:0] ry,
                      logic signed [31:0] rz, logic sat);
      rot_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (rx !== e.x) report_mismatch($sformatf("rot_x %0d, want %0d", rx, e.x));
      if (ry !== e.y) report_mismatch($sformatf("rot_y %0d, want %0d", ry, e.y));
      if (rz !== e.z) report_mismatch($sformatf("rot_z %0d, want %0d", rz, e.z));
      if (sat !== e.sat) report_mismatch($sformatf("saturated %0b, want %0b", sat, e.sat));
    endtask
  endclass

  rotate_scoreboard expected_rot = new();

  // Clock; the single reset is driven by the stimulus block
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive one request at the falling edge and hold it until accepted
  task automatic send_request(input logic [1:0] op, input logic signed [31:0] vx,
                              input logic signed [31:0] vy, input logic signed [31:0] vz,
                              input logic signed [15:0] nx, input logic signed [15:0] ny,
                              input logic signed [15:0] nz, input logic [ANGLE_BITS-1:0] ang);
    @(negedge clk);
    in_valid = 1'b1;
    opcode = op; vec_x = vx; vec_y = vy; vec_z = vz;
    axis_x = nx; axis_y = ny; axis_z = nz; angle = ang;
    do @(posedge clk); while (!in_ready);
    expected_rot.note_request(op, vx, vy, vz, nx, ny, nz, ang);
  endtask

  // Drop valid for a random gap
  task automatic idle_sender();
    @(negedge clk);
    in_valid = 1'b0;
    repeat ($urandom_range(4)) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_vec_comp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
    if (pick < 90) return $urandom;
    case ($urandom_range(3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh00010000;
      default: return 32'sh0;
    endcase
  endfunction

  // Unit-length axis in Q2.14 from a random direction
  task automatic rand_unit_axis(output logic signed [15:0] nx, output logic signed [15:0] ny,
                                output logic signed [15:0] nz);
    real ax, ay, az, len;
    do begin
      ax = $itor($signed($urandom_range(2000)) - 1000);
      ay = $itor($signed($urandom_range(2000)) - 1000);
      az = $itor($signed($urandom_range(2000)) - 1000);
      len = $sqrt(ax * ax + ay * ay + az * az);
    end while (len < 1.0);
    nx = $rtoi(ax / len * 16384.0);
    ny = $rtoi(ay / len * 16384.0);
    nz = $rtoi(az / len * 16384.0);
  endtask

  // Stimulus
  initial begin
    logic [1:0] op;
    logic signed [15:0] nx, ny, nz;
    logic [ANGLE_BITS-1:0] ang;
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0; vec_x = '0; vec_y = '0; vec_z = '0;
    axis_x = '0; axis_y = '0; axis_z = '0; angle = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each rotation at the octant boundaries and extremes
    send_request(OP_AXIS,  32'sh00010000, 32'sh00020000, 32'sh00030000, 16'sd0, 16'sd0,
                 16'sd16384, 16'd16384);
    send_request(OP_AXIS,  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sd9459, 16'sd9459,
                 16'sd9459, 16'd8192);
    send_request(OP_AXIS,  32'sh80000000, 32'sh7fffffff, 32'sh80000000, -16'sd32768,
                 16'sd32767, -16'sd32768, 16'd40000);
    send_request(OP_AXIS,  32'sh00100000, -32'sh00100000, 32'sh0, 16'sd16384, 16'sd16384,
                 16'sd16384, 16'd0);
    send_request(OP_AXIS,  32'sh12345678, 32'sh0, -32'sh1, 16'sd0, -16'sd16384, 16'sd0,
                 16'd65535);
    send_request(OP_ROT_X, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sd0, 16'sd0,
                 16'sd0, 16'd8192);
    send_request(OP_ROT_X, 32'sh00010000, 32'sh00010000, 32'sh0, 16'sd0, 16'sd0, 16'sd0,
                 16'd32768);
    send_request(OP_ROT_X, 32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sd0, 16'sd0,
                 16'sd0, 16'd24576);
    send_request(OP_ROT_Y, 32'sh00010000, 32'sh0, 32'sh00010000, 16'sd0, 16'sd0, 16'sd0,
                 16'd16384);
    send_request(OP_ROT_Y, 32'sh7fffffff, 32'sh0, 32'sh7fffffff, 16'sd0, 16'sd0, 16'sd0,
                 16'd57344);
    send_request(OP_ROT_Y, -32'sh00050000, 32'sh1, 32'sh3, -16'sd1, 16'sd1, -16'sd1,
                 16'd49152);
    send_request(OP_ROT_Z, 32'sh00010000, 32'sh0, 32'sh0, 16'sd0, 16'sd0, 16'sd0,
                 16'd1);
    send_request(OP_ROT_Z, 32'sh80000000, 32'sh7fffffff, 32'sh0, 16'sd0, 16'sd0, 16'sd0,
                 16'd40960);
    send_request(OP_ROT_Z, 32'sh7fffffff, 32'sh80000000, 32'sh0, 16'sd0, 16'sd0, 16'sd0,
                 16'd65535);
    send_request(OP_ROT_Z, -32'sh1, -32'sh1, -32'sh1, 16'sd32767, 16'sd32767, 16'sd32767,
                 16'd32767);

    // Random: mostly unit axes, some arbitrary non-unit axes
    for (int k = 0; k < 500; k++) begin
      if ((k < 100 || k >= 250) && $urandom_range(99) < 12) idle_sender();
      op = $urandom_range(3);
      ang = $urandom;
      pick = $urandom_range(99);
      if (pick < 75) rand_unit_axis(nx, ny, nz);
      else begin
        nx = $urandom; ny = $urandom; nz = $urandom;
      end
      send_request(op, rand_vec_comp(), rand_vec_comp(), rand_vec_comp(), nx, ny, nz, ang);
    end
    @(negedge clk);
    in_valid = 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls, one long hold-off, then a stretch always ready
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= 150 && rx_cycle < 350) out_ready = 1'b0;
      else if (rx_cycle >= 400 && rx_cycle < 700) out_ready = 1'b1;
      else out_ready = ($urandom_range(99) >= 12);
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      expected_rot.check_result(rot_x, rot_y, rot_z, saturated);
  end

  // Wait for the pipeline to drain, then give the verdict
  initial begin
    wait (stim_done);
    while (expected_rot.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("tb_axis_angle_vector_rotate: clean");
    else
      $display("tb_axis_angle_vector_rotate: errors");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("tb_axis_angle_vector_rotate: errors");
    $finish;
  end

endmodule
